[rtl/spts_pkg.sv]
package spts_pkg;

   // Fixed widths of the request and response fields
   localparam int unsigned MODE_W  = 2;
   localparam int unsigned PRICE_W = 16;
   localparam int unsigned POS_W   = 5;
   localparam int unsigned ENT_W   = 6;

   // Request mode codes; the fourth code only returns a response
   localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;
   localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SORT_I,
      ST_HELD,
      ST_CMP,
      ST_PLACE,
      ST_LOOP,
      ST_TOP,
      ST_BOT,
      ST_DIV,
      ST_POS
   } state_type;

   // Table read address source
   typedef enum logic [2:0] {
      RD_I,
      RD_K,
      RD_LOW,
      RD_HIGH,
      RD_POS
   } rd_sel_type;

   // Response field source
   typedef enum logic [1:0] {
      RSP_APPEND,
      RSP_MISS,
      RSP_LOW,
      RSP_POS
   } rsp_kind_type;

   typedef struct packed {
      logic         take;
      logic         append;
      logic         clear;
      logic         sort_init;
      logic         held_load;
      logic         shift;
      logic         place;
      logic         srch_init;
      logic         top_load;
      logic         bot_load;
      logic         div_step;
      logic         pos_load;
      logic         move;
      rd_sel_type   rd_sel;
      logic         rsp_load;
      rsp_kind_type rsp_kind;
   } cmd_type;

   typedef struct packed {
      logic sort_end;
      logic shift;
      logic k_zero;
      logic span_ok;
      logic in_range;
      logic one_left;
      logic flat;
      logic top_hit;
      logic div_done;
      logic probe_hit;
      logic full;
   } status_type;

endpackage

[rtl/spts_ram.sv]
module spts_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, read one word registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/spts_ctrl.sv]
module spts_ctrl
   import spts_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [MODE_W-1:0] req_mode,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  status_type        status,
   output cmd_type           cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Sequence sort and search, issue datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_sel   = RD_I;
      cmd.rsp_kind = RSP_MISS;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.take = 1'b1;
               unique case (req_mode)
                  MODE_APPEND: begin
                     cmd.append   = 1'b1;
                     cmd.rsp_load = 1'b1;
                     cmd.rsp_kind = RSP_APPEND;
                  end
                  MODE_CLEAR: begin
                     cmd.clear    = 1'b1;
                     cmd.rsp_load = 1'b1;
                  end
                  MODE_SEARCH: begin
                     cmd.sort_init = 1'b1;
                     state_in      = ST_SORT_I;
                  end
                  default: begin
                     cmd.rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_SORT_I: begin
            if (status.sort_end) begin
               cmd.srch_init = 1'b1;
               state_in      = ST_LOOP;
            end else begin
               cmd.rd_sel = RD_I;
               state_in   = ST_HELD;
            end
         end
         ST_HELD: begin
            cmd.held_load = 1'b1;
            cmd.rd_sel    = RD_K;
            state_in      = ST_CMP;
         end
         ST_CMP: begin
            if (status.shift) begin
               cmd.shift  = 1'b1;
               cmd.rd_sel = RD_K;
               state_in   = status.k_zero ? ST_PLACE : ST_CMP;
            end else begin
               cmd.place = 1'b1;
               state_in  = ST_SORT_I;
            end
         end
         ST_PLACE: begin
            cmd.place = 1'b1;
            state_in  = ST_SORT_I;
         end
         ST_LOOP: begin
            if (status.span_ok) begin
               cmd.rd_sel = RD_LOW;
               state_in   = ST_TOP;
            end else begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_TOP: begin
            cmd.top_load = 1'b1;
            cmd.rd_sel   = RD_HIGH;
            state_in     = ST_BOT;
         end
         ST_BOT: begin
            if (!status.in_range) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end else if (status.one_left) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_kind = status.top_hit ? RSP_LOW : RSP_MISS;
               state_in     = ST_IDLE;
            end else if (status.flat) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_kind = RSP_LOW;
               state_in     = ST_IDLE;
            end else begin
               cmd.bot_load = 1'b1;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               cmd.pos_load = 1'b1;
               cmd.rd_sel   = RD_POS;
               state_in     = ST_POS;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_POS: begin
            if (status.probe_hit) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_kind = RSP_POS;
               state_in     = ST_IDLE;
            end else begin
               cmd.move = 1'b1;
               state_in = ST_LOOP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && rsp_stall);
   end

`ifndef SYNTH
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(cmd.rsp_load && rsp_valid_ff && rsp_stall))
      else $error("response overwritten while stalled");
   a_div_to_probe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && status.div_done) |=> (state_ff == ST_POS))
      else $error("divide did not hand over to probe read");
   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("request taken while a search is running");
`endif

endmodule

[rtl/spts_dpath.sv]
module spts_dpath
   import spts_pkg::*;
#(
   parameter int TABLE_DEPTH = 32,
   parameter int PRICE_BITS  = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  logic [PRICE_W-1:0] req_price,
   output status_type         status,
   output logic               rsp_found,
   output logic [POS_W-1:0]   rsp_position,
   output logic               rsp_rejected,
   output logic [ENT_W-1:0]   rsp_entries
);

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int SW     = CNT_W + 1;
   localparam int SPAN_W = IDX_W + PRICE_BITS;
   localparam int DC_W   = $clog2(SPAN_W + 1);

   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        i_ff, i_in;
   logic signed [SW-1:0]    k_ff, k_in, low_ff, low_in, high_ff, high_in, pos_ff, pos_in;
   logic [PRICE_BITS-1:0]   held_ff, held_in, x_ff, x_in, top_ff, top_in;
   logic [PRICE_BITS-1:0]   dvs_ff, dvs_in, rem_ff, rem_in;
   logic [SPAN_W-1:0]       quo_ff, quo_in;
   logic [DC_W-1:0]         dcnt_ff, dcnt_in;
   logic                    found_ff, found_in, rejected_ff, rejected_in;
   logic [POS_W-1:0]        position_ff, position_in;
   logic [ENT_W-1:0]        entries_ff, entries_in;

   logic [PRICE_BITS-1:0]   price_in, rdata, wdata;
   logic [IDX_W-1:0]        raddr, waddr;
   logic                    we;
   logic signed [SW-1:0]    k_next, width_s;
   logic [PRICE_BITS:0]     trial, trial_sub;
   logic                    qbit;

   assign price_in = PRICE_BITS'(req_price);
   assign k_next   = k_ff + SW'(1);
   assign width_s  = high_ff - low_ff;
   assign trial    = {rem_ff, quo_ff[SPAN_W-1]};
   assign trial_sub = trial - {1'b0, dvs_ff};
   assign qbit     = (trial >= {1'b0, dvs_ff});

   // Status for the controller
   always_comb begin
      status.sort_end  = (i_ff >= count_ff);
      status.shift     = (rdata < held_ff);
      status.k_zero    = (k_ff == '0);
      status.span_ok   = (low_ff <= high_ff);
      status.in_range  = (x_ff <= top_ff) && (x_ff >= rdata);
      status.one_left  = (low_ff == high_ff);
      status.flat      = (top_ff == rdata);
      status.top_hit   = (top_ff == x_ff);
      status.div_done  = (dcnt_ff == '0);
      status.probe_hit = (rdata == x_ff);
      status.full      = (count_ff == CNT_W'(TABLE_DEPTH));
   end

   // Next values of table, sort and search registers
   always_comb begin
      count_in    = count_ff;
      i_in        = i_ff;
      k_in        = k_ff;
      low_in      = low_ff;
      high_in     = high_ff;
      pos_in      = pos_ff;
      held_in     = held_ff;
      x_in        = x_ff;
      top_in      = top_ff;
      dvs_in      = dvs_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      dcnt_in     = dcnt_ff;
      found_in    = found_ff;
      rejected_in = rejected_ff;
      position_in = position_ff;
      entries_in  = entries_ff;
      if (cmd.take) begin
         x_in = price_in;
      end
      if (cmd.append && !status.full) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.clear) begin
         count_in = '0;
      end
      if (cmd.sort_init) begin
         i_in = CNT_W'(1);
      end
      if (cmd.held_load) begin
         held_in = rdata;
         k_in    = SW'(i_ff) - SW'(1);
      end
      if (cmd.shift) begin
         k_in = k_ff - SW'(1);
      end
      if (cmd.place) begin
         i_in = i_ff + CNT_W'(1);
      end
      if (cmd.srch_init) begin
         low_in  = '0;
         high_in = SW'(count_ff) - SW'(1);
      end
      if (cmd.top_load) begin
         top_in = rdata;
      end
      // Start the probe divide: span over endpoint gap
      if (cmd.bot_load) begin
         dvs_in  = top_ff - rdata;
         quo_in  = SPAN_W'(width_s[IDX_W-1:0]) * SPAN_W'(top_ff - x_ff);
         rem_in  = '0;
         dcnt_in = DC_W'(SPAN_W);
      end
      // One restoring divide step per cycle
      if (cmd.div_step) begin
         rem_in  = qbit ? trial_sub[PRICE_BITS-1:0] : trial[PRICE_BITS-1:0];
         quo_in  = {quo_ff[SPAN_W-2:0], qbit};
         dcnt_in = dcnt_ff - DC_W'(1);
      end
      if (cmd.pos_load) begin
         pos_in = low_ff + SW'(quo_ff[IDX_W-1:0]);
      end
      // Narrow the window away from the probe
      if (cmd.move) begin
         if (rdata < x_ff) begin
            high_in = pos_ff - SW'(1);
         end else begin
            low_in = pos_ff + SW'(1);
         end
      end
      if (cmd.rsp_load) begin
         entries_in  = ENT_W'(count_in);
         found_in    = 1'b0;
         rejected_in = 1'b0;
         position_in = '0;
         unique case (cmd.rsp_kind)
            RSP_APPEND: rejected_in = status.full;
            RSP_MISS:   found_in    = 1'b0;
            RSP_LOW: begin
               found_in    = 1'b1;
               position_in = POS_W'(low_ff);
            end
            RSP_POS: begin
               found_in    = 1'b1;
               position_in = POS_W'(pos_ff);
            end
            default: found_in = 1'b0;
         endcase
      end
   end

   // Table port selection
   always_comb begin
      unique case (cmd.rd_sel)
         RD_I:    raddr = i_ff[IDX_W-1:0];
         RD_K:    raddr = k_in[IDX_W-1:0];
         RD_LOW:  raddr = low_ff[IDX_W-1:0];
         RD_HIGH: raddr = high_ff[IDX_W-1:0];
         RD_POS:  raddr = pos_in[IDX_W-1:0];
         default: raddr = i_ff[IDX_W-1:0];
      endcase
      we = (cmd.append && !status.full) || cmd.shift || cmd.place;
      if (cmd.append) begin
         waddr = count_ff[IDX_W-1:0];
         wdata = price_in;
      end else begin
         waddr = k_next[IDX_W-1:0];
         wdata = cmd.shift ? rdata : held_ff;
      end
   end

   spts_ram #(
      .WIDTH (PRICE_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (waddr),
      .wr_data (wdata),
      .rd_addr (raddr),
      .rd_data (rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      k_ff        <= k_in;
      low_ff      <= low_in;
      high_ff     <= high_in;
      pos_ff      <= pos_in;
      held_ff     <= held_in;
      x_ff        <= x_in;
      top_ff      <= top_in;
      dvs_ff      <= dvs_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      dcnt_ff     <= dcnt_in;
      found_ff    <= found_in;
      rejected_ff <= rejected_in;
      position_ff <= position_in;
      entries_ff  <= entries_in;
   end

   assign rsp_found    = found_ff;
   assign rsp_position = position_ff;
   assign rsp_rejected = rejected_ff;
   assign rsp_entries  = entries_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");
   a_window_legal: assert property (@(posedge clock) disable iff (reset)
      cmd.top_load |-> (low_ff >= 0 && high_ff < SW'(count_ff)))
      else $error("search window outside stored entries");
   a_probe_in_window: assert property (@(posedge clock) disable iff (reset)
      cmd.pos_load |-> (pos_in >= low_ff && pos_in <= high_ff))
      else $error("probe position outside search window");
`endif

endmodule

[rtl/sorted_price_table_search_core.sv]
// Append, clear and the unused mode: response valid in the cycle after the request,
// one request per cycle while responses are taken.
// Search: insertion sort then interpolation probes over one table read port;
// each probe runs a restoring divide over index bits plus PRICE_BITS quotient
// bits. One request in flight; synchronous reset empties the table.
module sorted_price_table_search_core
   import spts_pkg::*;
#(
   parameter int TABLE_DEPTH = 32,
   parameter int PRICE_BITS  = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [MODE_W-1:0]  req_mode,
   input  logic [PRICE_W-1:0] req_price,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_found,
   output logic [POS_W-1:0]   rsp_position,
   output logic               rsp_rejected,
   output logic [ENT_W-1:0]   rsp_entries
);

   cmd_type    cmd;
   status_type status;

   spts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   spts_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .PRICE_BITS  (PRICE_BITS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_price    (req_price),
      .status       (status),
      .rsp_found    (rsp_found),
      .rsp_position (rsp_position),
      .rsp_rejected (rsp_rejected),
      .rsp_entries  (rsp_entries)
   );

endmodule

[verif/tb_sorted_price_table_search_core.sv]
module tb_sorted_price_table_search_core
   import spts_pkg::*;
;

   localparam int DEPTH       = 32;
   localparam int RAND_ITEMS  = 890;
   localparam int IDLE_LIMIT  = 20000;
   localparam int LONG_HOLD   = 3000;

   typedef struct {
      logic [MODE_W-1:0]  mode;
      logic [PRICE_W-1:0] price;
      bit                 known;
      logic               found;
      logic [POS_W-1:0]   position;
      logic               rejected;
      logic [ENT_W-1:0]   entries;
   } stim_row_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] position;
      logic             rejected;
      logic [ENT_W-1:0] entries;
   } price_result_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [MODE_W-1:0]  req_mode;
   logic [PRICE_W-1:0] req_price;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_found;
   logic [POS_W-1:0]   rsp_position;
   logic               rsp_rejected;
   logic [ENT_W-1:0]   rsp_entries;

   // predictor state
   logic [PRICE_W-1:0] shadow_table [DEPTH];
   int                 shadow_count;

   price_result_type   pending_results [$];
   stim_row_type       directed_rows [$];
   int                 mismatches;
   int                 checked;
   int                 searches;
   int                 hits;
   int                 rejects;
   int                 idle_cycles;
   bit                 hold_long;
   bit                 stim_done;

   sorted_price_table_search_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_mode    (req_mode),
      .req_price   (req_price),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_found   (rsp_found),
      .rsp_position(rsp_position),
      .rsp_rejected(rsp_rejected),
      .rsp_entries (rsp_entries)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // sort the shadow table descending, stable
   function automatic void sort_shadow_desc();
      logic [PRICE_W-1:0] held;
      int k;
      for (int i = 1; i < shadow_count; i++) begin
         held = shadow_table[i];
         k = i - 1;
         while (k >= 0 && shadow_table[k] < held) begin
            shadow_table[k+1] = shadow_table[k];
            k--;
         end
         shadow_table[k+1] = held;
      end
   endfunction

   // interpolation search over the sorted shadow table; -1 on miss
   function automatic int find_price(logic [PRICE_W-1:0] x);
      int lo;
      int hi;
      int pos;
      longint unsigned span;
      logic [PRICE_W-1:0] top;
      logic [PRICE_W-1:0] bot;
      lo = 0;
      hi = shadow_count - 1;
      while (lo <= hi && x <= shadow_table[lo] && x >= shadow_table[hi]) begin
         top = shadow_table[lo];
         bot = shadow_table[hi];
         if (lo == hi) return (top == x) ? lo : -1;
         if (top == bot) return lo;
         span = longint'(hi - lo) * longint'(top - x);
         pos = lo + int'(span / longint'(top - bot));
         if (shadow_table[pos] == x) return pos;
         if (shadow_table[pos] < x) hi = pos - 1;
         else lo = pos + 1;
      end
      return -1;
   endfunction

   function automatic price_result_type predict_price_request(logic [MODE_W-1:0] mode,
                                                              logic [PRICE_W-1:0] price);
      price_result_type r;
      int hit;
      r = '{found: 1'b0, position: '0, rejected: 1'b0, entries: '0};
      case (mode)
         MODE_APPEND: begin
            if (shadow_count < DEPTH) begin
               shadow_table[shadow_count] = price;
               shadow_count++;
            end else begin
               r.rejected = 1'b1;
            end
         end
         MODE_CLEAR: shadow_count = 0;
         MODE_SEARCH: begin
            sort_shadow_desc();
            hit = find_price(price);
            if (hit >= 0) begin
               r.found = 1'b1;
               r.position = hit[POS_W-1:0];
            end
         end
         default: ;
      endcase
      r.entries = shadow_count[ENT_W-1:0];
      return r;
   endfunction

   // offer one request and wait for it to be taken
   task automatic send_request(logic [MODE_W-1:0] mode, logic [PRICE_W-1:0] price,
                               bit known, price_result_type typed);
      price_result_type predicted;
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_price <= price;
      do @(posedge clock); while (req_stall);
      predicted = predict_price_request(mode, price);
      if (known && predicted != typed) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: directed table row disagrees with predictor, mode %0d price %0d",
                     mode, price);
      end
      if (mode == MODE_SEARCH) searches++;
      if (predicted.found) hits++;
      if (predicted.rejected) rejects++;
      pending_results.push_back(predicted);
      @(negedge clock);
   endtask

   task automatic add_row(logic [MODE_W-1:0] mode, logic [PRICE_W-1:0] price, bit known,
                          logic found, logic [POS_W-1:0] position, logic rejected,
                          logic [ENT_W-1:0] entries);
      directed_rows.push_back('{mode, price, known, found, position, rejected, entries});
   endtask

   task automatic gap_cycles(int n);
      req_valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // random price biased toward values already stored
   function automatic logic [PRICE_W-1:0] pick_price();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 5 && shadow_count > 0)
         return shadow_table[$urandom_range(0, shadow_count - 1)];
      if (sel == 5) return {PRICE_W{1'b1}};
      if (sel == 6) return '0;
      if (sel == 7) return PRICE_W'($urandom_range(0, 15));
      return PRICE_W'($urandom);
   endfunction

   // receiver stall pattern, with one long hold-off
   initial begin
      rsp_stall = 1'b1;
      @(negedge clock);
      while (!stim_done) begin
         if (hold_long) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
            hold_long = 1'b0;
         end else begin
            case ($urandom_range(0, 3))
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 1) == 1);
               2: rsp_stall <= ($urandom_range(0, 7) == 0);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
            repeat ($urandom_range(1, 40)) @(negedge clock);
         end
      end
      rsp_stall <= 1'b0;
   end

   // compare each response with the oldest prediction
   always @(posedge clock) begin
      price_result_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: response with nothing expected");
         end else begin
            exp_r = pending_results.pop_front();
            checked++;
            if (rsp_found !== exp_r.found || rsp_position !== exp_r.position ||
                rsp_rejected !== exp_r.rejected || rsp_entries !== exp_r.entries) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: exp f%0d p%0d r%0d e%0d got f%0d p%0d r%0d e%0d",
                           exp_r.found, exp_r.position, exp_r.rejected, exp_r.entries,
                           rsp_found, rsp_position, rsp_rejected, rsp_entries);
            end
         end
      end
   end

   // count cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("ERROR: no progress for %0d cycles", IDLE_LIMIT);
      $display("FAIL sorted_price_table_search_core");
      $finish;
   end

   initial begin
      price_result_type typed;
      int burst;
      int kind;
      int fill;
      bit drained;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_APPEND;
      req_price = '0;
      mismatches = 0;
      checked = 0;
      searches = 0;
      hits = 0;
      rejects = 0;
      hold_long = 1'b0;
      stim_done = 1'b0;
      drained = 1'b0;
      shadow_count = 0;
      for (int i = 0; i < DEPTH; i++) shadow_table[i] = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty search, unused mode, extremes, ties
      add_row(MODE_SEARCH, 16'h1234, 1, 0, 0, 0, 0);
      add_row(MODE_NONE,   16'hFFFF, 1, 0, 0, 0, 0);
      add_row(MODE_APPEND, 16'h0000, 1, 0, 0, 0, 1);
      add_row(MODE_SEARCH, 16'h0000, 1, 1, 0, 0, 1);
      add_row(MODE_SEARCH, 16'h0001, 1, 0, 0, 0, 1);
      add_row(MODE_APPEND, 16'hFFFF, 1, 0, 0, 0, 2);
      add_row(MODE_APPEND, 16'h8000, 1, 0, 0, 0, 3);
      add_row(MODE_APPEND, 16'h8000, 1, 0, 0, 0, 4);
      add_row(MODE_SEARCH, 16'hFFFF, 1, 1, 0, 0, 4);
      add_row(MODE_SEARCH, 16'h8000, 0, 0, 0, 0, 0);
      add_row(MODE_SEARCH, 16'h0000, 1, 1, 3, 0, 4);
      add_row(MODE_SEARCH, 16'h7FFF, 1, 0, 0, 0, 4);
      add_row(MODE_NONE,   16'h5555, 1, 0, 0, 0, 4);
      add_row(MODE_CLEAR,  16'hAAAA, 1, 0, 0, 0, 0);
      add_row(MODE_APPEND, 16'h0042, 1, 0, 0, 0, 1);
      add_row(MODE_APPEND, 16'h0042, 1, 0, 0, 0, 2);
      add_row(MODE_SEARCH, 16'h0042, 1, 1, 0, 0, 2);
      add_row(MODE_CLEAR,  16'h0000, 1, 0, 0, 0, 0);
      foreach (directed_rows[i]) begin
         typed = '{directed_rows[i].found, directed_rows[i].position,
                   directed_rows[i].rejected, directed_rows[i].entries};
         send_request(directed_rows[i].mode, directed_rows[i].price,
                      directed_rows[i].known, typed);
      end
      // fill ascending to the limit, overflow, then search the sorted table
      for (int i = 0; i < DEPTH + 2; i++)
         send_request(MODE_APPEND, PRICE_W'(i * 1000 + 7), 0, typed);
      send_request(MODE_SEARCH, 16'd7, 0, typed);
      send_request(MODE_SEARCH, PRICE_W'(31 * 1000 + 7), 0, typed);

      // hold the receiver for a long stretch while requests keep coming
      hold_long = 1'b1;
      for (int i = 0; i < 6; i++)
         send_request(i[0] ? MODE_SEARCH : MODE_NONE, pick_price(), 0, typed);

      // random bursts of well-formed fill/search sequences plus noise
      for (int n = 0; n < RAND_ITEMS; ) begin
         burst = $urandom_range(1, 12);
         for (int b = 0; b < burst && n < RAND_ITEMS; b++, n++) begin
            kind = $urandom_range(0, 99);
            if (kind < 50) send_request(MODE_APPEND, pick_price(), 0, typed);
            else if (kind < 88) send_request(MODE_SEARCH, pick_price(), 0, typed);
            else if (kind < 94) send_request(MODE_CLEAR, PRICE_W'($urandom), 0, typed);
            else if (kind < 97) send_request(MODE_NONE, PRICE_W'($urandom), 0, typed);
            else begin
               // refill to full with random width prices
               fill = $urandom_range(0, 3);
               send_request(MODE_CLEAR, '0, 0, typed);
               for (int f = 0; f < DEPTH; f++)
                  send_request(MODE_APPEND, fill == 0 ? PRICE_W'($urandom_range(0, 3))
                                                       : pick_price(), 0, typed);
               n += DEPTH;
            end
         end
         // pause once until every response is back
         if (!drained && n > 400) begin
            drained = 1'b1;
            req_valid <= 1'b0;
            wait (pending_results.size() == 0);
            @(negedge clock);
         end
         if ($urandom_range(0, 2) != 0) gap_cycles($urandom_range(1, 25));
      end

      req_valid <= 1'b0;
      stim_done = 1'b1;
      wait (pending_results.size() == 0);
      repeat (50) @(posedge clock);
      $display("Covered %0d responses: %0d searches (%0d hits), %0d full-table rejects.",
               checked, searches, hits, rejects);
      if (mismatches == 0)
         $display("PASS sorted_price_table_search_core");
      else
         $display("FAIL sorted_price_table_search_core");
      $finish;
   end

endmodule
